[hdl/napt_pkg.sv]
// ----------------------------------------------------------------------------
// napt_pkg
// shared types and constants for the port translation table
// ----------------------------------------------------------------------------
package napt_pkg;

  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [16:0] PORT_BASE    = 17'd1024;
  localparam logic [16:0] PORT_SPAN    = 17'd58976;
  localparam logic [15:0] LFSR_MASK    = 16'hB400;
  localparam logic [15:0] SEED_DEFAULT = 16'd44257;

  localparam logic [2:0] ST_OUT_OK   = 3'd0;
  localparam logic [2:0] ST_IN_OK    = 3'd1;
  localparam logic [2:0] ST_BAD_PROTO = 3'd2;
  localparam logic [2:0] ST_NO_MAP   = 3'd3;
  localparam logic [2:0] ST_NO_PORT  = 3'd4;

  localparam logic CFG_PUBLIC_IP = 1'b0;
  localparam logic CFG_PORT_SEED = 1'b1;

  localparam int ENTRY_W = 120;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dest_port;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] new_ip;
    logic [15:0] new_port;
  } resp_t;

  typedef struct packed {
    logic [31:0] lan_ip;
    logic [15:0] priv_port;
    logic [15:0] ext_port;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
    logic [7:0]  proto;
  } entry_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_MASK;
    end
    return s;
  endfunction

  // maps v to PORT_BASE + (v mod 58976) for v < 65536: one compare and subtract
  function automatic logic [15:0] lfsr_to_port(input logic [15:0] v);
    logic [16:0] w;
    w = {1'b0, v};
    if (w >= PORT_SPAN) begin
      w = w - PORT_SPAN;
    end
    w = w + PORT_BASE;
    return w[15:0];
  endfunction

endpackage

[hdl/napt_ram.sv]
// ----------------------------------------------------------------------------
// napt_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module napt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/napt_port_translation_table.sv]
// ----------------------------------------------------------------------------
// napt_port_translation_table
// nat port mapping table with sequential search
// ----------------------------------------------------------------------------
// usage:
//   pulse start with req while busy is low; the transaction is taken then.
//   one result per request comes on resp with resp_valid high for one cycle;
//   the receiver cannot stall it.
//   cfg_valid/cfg_ready write the wan address (index 0) or port_seed (index 1);
//   a seed write also reloads the port lfsr. write only while idle.
// table passes:
//   each table pass reads every entry through the single entry ram read
//   port. inbound: one pass. outbound hit: one pass. outbound miss: one
//   pass for lookup and free slot, then one pass per port attempt, up to
//   MAX_ATTEMPTS, then a write of the new entry. a bad protocol skips the
//   table and goes straight to the result.
// reset:
//   valid bits clear at once in flip-flops, no clearing pass; the lfsr
//   loads the default seed and the wan address clears.
// ----------------------------------------------------------------------------
module napt_port_translation_table #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_ATTEMPTS  = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  napt_pkg::req_t     req,
  output logic               resp_valid,
  output napt_pkg::resp_t    resp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int TW = $clog2(MAX_ATTEMPTS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_PICK  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state;
  napt_pkg::req_t    cur;
  napt_pkg::resp_t   res;
  logic [31:0]       wan_ip;
  logic [15:0]       port_lfsr;
  logic [15:0]       port;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CW-1:0]     cnt;
  logic              rd_ok;
  logic [AW-1:0]     rd_idx;
  logic              hit;
  logic [AW-1:0]     hit_idx;
  logic              free_ok;
  logic [AW-1:0]     free_idx;
  logic [TW-1:0]     tries;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  napt_pkg::entry_t  wentry;
  napt_pkg::entry_t  rentry;
  logic              m_lan;
  logic              m_ext;
  logic              valid_rd;

  napt_ram #(.WIDTH(napt_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(wentry),
    .rdata(rentry)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign ram_we    = (state == S_WRITE);
  assign ram_addr  = (state == S_WRITE) ? free_idx : cnt[AW-1:0];

  always_comb begin
    wentry.lan_ip      = cur.src_ip;
    wentry.priv_port   = cur.src_port;
    wentry.ext_port    = port;
    wentry.remote_ip   = cur.dst_ip;
    wentry.remote_port = cur.dest_port;
    wentry.proto       = cur.protocol;
  end

  assign valid_rd = rd_ok && valid[rd_idx];
  assign m_lan = valid_rd && rentry.lan_ip == cur.src_ip &&
                 rentry.priv_port == cur.src_port && rentry.proto == cur.protocol;
  // inbound: remote=src, public=dst port, remote port=src port
  always_comb begin
    if (cur.req_type) begin
      m_ext = valid_rd && rentry.remote_ip == cur.src_ip &&
              rentry.ext_port == cur.dest_port &&
              rentry.remote_port == cur.src_port && rentry.proto == cur.protocol;
    end else begin
      m_ext = valid_rd && rentry.remote_ip == cur.dst_ip &&
              rentry.ext_port == port &&
              rentry.remote_port == cur.dest_port && rentry.proto == cur.protocol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      wan_ip     <= '0;
      port_lfsr  <= napt_pkg::SEED_DEFAULT;
      resp_valid <= 1'b0;
      rd_ok      <= 1'b0;
    end else begin
      resp_valid <= 1'b0;
      rd_ok      <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == napt_pkg::CFG_PUBLIC_IP) begin
              wan_ip <= cfg_data;
            end else begin
              port_lfsr <= (cfg_data[15:0] != 16'd0) ? cfg_data[15:0]
                                                      : napt_pkg::SEED_DEFAULT;
            end
          end
          if (start) begin
            cur     <= req;
            cnt     <= '0;
            hit     <= 1'b0;
            free_ok <= 1'b0;
            if (req.protocol != napt_pkg::PROTO_TCP &&
                req.protocol != napt_pkg::PROTO_UDP) begin
              res   <= '{napt_pkg::ST_BAD_PROTO, 32'd0, 16'd0};
              state <= S_DONE;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK, S_SCAN: begin
          if (cnt < CW'(TABLE_ENTRIES)) begin
            rd_ok  <= 1'b1;
            rd_idx <= cnt[AW-1:0];
            cnt    <= cnt + 1'b1;
          end
          if (rd_ok) begin
            if (state == S_LOOK && !free_ok && !valid[rd_idx]) begin
              free_ok  <= 1'b1;
              free_idx <= rd_idx;
            end
            if (state == S_LOOK && !hit && (cur.req_type ? m_ext : m_lan)) begin
              hit     <= 1'b1;
              hit_idx <= rd_idx;
            end
            if (state == S_SCAN && m_ext) begin
              hit <= 1'b1;
            end
          end
          if (cnt == CW'(TABLE_ENTRIES) && !rd_ok) begin
            if (state == S_LOOK) begin
              if (cur.req_type) begin
                if (hit) begin
                  cnt   <= CW'(hit_idx);
                  state <= S_PICK;
                end else begin
                  res   <= '{napt_pkg::ST_NO_MAP, 32'd0, 16'd0};
                  state <= S_DONE;
                end
              end else if (hit) begin
                cnt   <= CW'(hit_idx);
                state <= S_PICK;
              end else if (!free_ok) begin
                res   <= '{napt_pkg::ST_NO_PORT, 32'd0, 16'd0};
                state <= S_DONE;
              end else begin
                tries     <= TW'(1);
                port_lfsr <= napt_pkg::lfsr_step(port_lfsr);
                port      <= napt_pkg::lfsr_to_port(napt_pkg::lfsr_step(port_lfsr));
                cnt       <= '0;
                state     <= S_SCAN;
              end
            end else begin
              if (!hit) begin
                state <= S_WRITE;
              end else if (tries == TW'(MAX_ATTEMPTS)) begin
                res   <= '{napt_pkg::ST_NO_PORT, 32'd0, 16'd0};
                state <= S_DONE;
              end else begin
                tries     <= tries + 1'b1;
                port_lfsr <= napt_pkg::lfsr_step(port_lfsr);
                port      <= napt_pkg::lfsr_to_port(napt_pkg::lfsr_step(port_lfsr));
                hit       <= 1'b0;
                cnt       <= '0;
              end
            end
          end
        end
        S_PICK: begin
          // fetch the matched entry: address held on cnt until the registered read returns
          if (rd_ok) begin
            if (cur.req_type) begin
              res <= '{napt_pkg::ST_IN_OK, rentry.lan_ip, rentry.priv_port};
            end else begin
              res <= '{napt_pkg::ST_OUT_OK, wan_ip, rentry.ext_port};
            end
            state <= S_DONE;
          end else begin
            rd_ok  <= 1'b1;
            rd_idx <= cnt[AW-1:0];
          end
        end
        S_WRITE: begin
          valid[free_idx] <= 1'b1;
          res   <= '{napt_pkg::ST_OUT_OK, wan_ip, port};
          state <= S_DONE;
        end
        S_DONE: begin
          resp_valid <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign resp = res;

`ifndef ASSERT_OFF
  a_resp_idle: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> state == S_IDLE)
    else $error("result while busy");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cfg_ready)
    else $error("config ready while busy");
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> free_ok && !valid[free_idx])
    else $error("write to used slot");
  a_lfsr_nz: assert property (@(posedge clk) disable iff (rst)
    port_lfsr != 16'd0)
    else $error("lfsr zero");
`endif

endmodule
